/* design/nif_pkg.sv */
package nif_pkg;

	// Frame shape.
	localparam int DATA_BITS = 32;
	localparam int KEY_W     = 32;
	localparam int DUR_W     = 15;
	localparam int MARGIN_W  = 10;
	localparam int TARGET_W  = 14;
	localparam int POS_W     = 7;

	localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
	// Position just past the last data space; a complete data frame has one more duration.
	localparam logic [POS_W-1:0] DATA_END = POS_W'(2 + 2 * DATA_BITS);

	// Nominal durations in microseconds.
	localparam logic [TARGET_W-1:0] LEADER_MARK  = TARGET_W'(9000);
	localparam logic [TARGET_W-1:0] REPEAT_SPACE = TARGET_W'(2250);
	localparam logic [TARGET_W-1:0] DATA_SPACE   = TARGET_W'(4500);
	localparam logic [TARGET_W-1:0] BIT_MARK     = TARGET_W'(560);
	localparam logic [TARGET_W-1:0] ONE_SPACE    = TARGET_W'(1690);
	localparam logic [TARGET_W-1:0] ZERO_SPACE   = TARGET_W'(560);

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(200);

	// Register map.
	localparam int ADDR_W = 3;
	localparam logic REG_MATCH_MARGIN = 1'b0;

	// Queue between the classifier and the frame sequencer.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [DUR_W-1:0] duration;
		logic             frame_end;
	} item_t;

	typedef struct packed {
		logic             frame_ok;
		logic             is_repeat;
		logic [KEY_W-1:0] key_code;
	} result_t;

	typedef struct packed {
		logic leader;
		logic rpt_space;
		logic data_space;
		logic bit_mark;
		logic one_space;
		logic zero_space;
	} match_t;

	typedef struct packed {
		match_t match;
		logic   frame_end;
	} class_t;

	function automatic logic in_window(
		input logic [DUR_W-1:0]    d,
		input logic [TARGET_W-1:0] target,
		input logic [MARGIN_W-1:0] margin
	);
		logic [DUR_W-1:0] t;
		logic [DUR_W-1:0] m;
		logic [DUR_W-1:0] lo;
		logic [DUR_W-1:0] hi;
		t  = DUR_W'(target);
		m  = DUR_W'(margin);
		lo = (t > m) ? (t - m) : '0;
		hi = t + m;
		return (d >= lo) && (d <= hi);
	endfunction

endpackage

/* design/nif_front.sv */
module nif_front import nif_pkg::*; (
	input  logic [MARGIN_W-1:0] margin,
	input  item_t               item,
	output class_t              cls
);

	// Every window is checked at once; the sequencer picks the one its position needs.
	always_comb begin
		cls.frame_end        = item.frame_end;
		cls.match.leader     = in_window(item.duration, LEADER_MARK, margin);
		cls.match.rpt_space  = in_window(item.duration, REPEAT_SPACE, margin);
		cls.match.data_space = in_window(item.duration, DATA_SPACE, margin);
		cls.match.bit_mark   = in_window(item.duration, BIT_MARK, margin);
		cls.match.one_space  = in_window(item.duration, ONE_SPACE, margin);
		cls.match.zero_space = in_window(item.duration, ZERO_SPACE, margin);
	end

endmodule

/* design/nif_queue.sv */
module nif_queue import nif_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  class_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output logic   rd_valid,
	output class_t rd_data
);

	class_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("classification queue count beyond depth");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> count_q != '0)
		else $error("sequencer took from an empty classification queue");

endmodule

/* design/nif_back.sv */
module nif_back import nif_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cls_valid,
	input  class_t  cls,
	output logic    cls_take,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic [POS_W-1:0]     pos_q;
	logic [DATA_BITS-1:0] shift_q;
	logic                 failed_q;
	logic                 rpt_q;

	logic [POS_W-1:0]     pos_d;
	logic [DATA_BITS-1:0] shift_d;
	logic                 failed_d;
	logic                 rpt_d;
	logic                 frame_ok;
	logic                 res_full;
	logic                 res_wr;
	logic                 res_rd;
	result_t              res_new;

	result_t              res_mem_q [2];
	logic                 res_wr_ptr_q;
	logic                 res_rd_ptr_q;
	logic [1:0]           res_cnt_q;

	assign res_full = (res_cnt_q == 2'd2);
	assign cls_take = cls_valid && (!cls.frame_end || !res_full);
	assign res_wr   = cls_take && cls.frame_end;
	assign res_rd   = pop && (res_cnt_q != '0);
	assign empty    = (res_cnt_q == '0);
	assign result   = res_mem_q[res_rd_ptr_q];

	always_comb begin
		shift_d  = shift_q;
		failed_d = failed_q;
		rpt_d    = rpt_q;
		if (!failed_q && !rpt_q) begin
			if (pos_q == '0) begin
				failed_d = !cls.match.leader;
			end else if (pos_q == POS_W'(1)) begin
				if (cls.match.rpt_space) begin
					rpt_d = 1'b1;
				end else if (!cls.match.data_space) begin
					failed_d = 1'b1;
				end
			end else if (pos_q < DATA_END) begin
				if (!pos_q[0]) begin
					failed_d = !cls.match.bit_mark;
				end else if (cls.match.one_space) begin
					shift_d = {shift_q[DATA_BITS-2:0], 1'b1};
				end else if (cls.match.zero_space) begin
					shift_d = {shift_q[DATA_BITS-2:0], 1'b0};
				end else begin
					failed_d = 1'b1;
				end
			end
		end
		pos_d = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : pos_q;

		frame_ok          = rpt_d || (!failed_d && pos_q >= DATA_END);
		res_new.frame_ok  = frame_ok;
		res_new.is_repeat = rpt_d;
		res_new.key_code  = (frame_ok && !rpt_d) ? KEY_W'(shift_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			shift_q  <= '0;
			failed_q <= 1'b0;
			rpt_q    <= 1'b0;
		end else if (cls_take) begin
			if (cls.frame_end) begin
				pos_q    <= '0;
				shift_q  <= '0;
				failed_q <= 1'b0;
				rpt_q    <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				shift_q  <= shift_d;
				failed_q <= failed_d;
				rpt_q    <= rpt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_mem_q[res_wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= 1'b0;
			res_rd_ptr_q <= 1'b0;
			res_cnt_q    <= '0;
		end else begin
			if (res_wr) begin
				res_wr_ptr_q <= !res_wr_ptr_q;
			end
			if (res_rd) begin
				res_rd_ptr_q <= !res_rd_ptr_q;
			end
			if (res_wr && !res_rd) begin
				res_cnt_q <= res_cnt_q + 2'd1;
			end else if (res_rd && !res_wr) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |=> pos_q == '0 && !failed_q && !rpt_q)
		else $error("frame state not cleared after frame end");

	a_repeat_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.is_repeat |-> result.frame_ok && result.key_code == '0)
		else $error("repeat result without success or with a key code");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= 2'd2)
		else $error("result queue count beyond depth");

endmodule

/* design/nec_ir_frame_decoder.sv */
// NEC infrared frame decoder. Each input beat carries one measured mark or
// space duration in microseconds (marks at even positions of the frame) and
// a flag on the last duration of the frame. Every duration is compared with
// its nominal value plus or minus the match_margin register (byte address 0,
// reset 200). A 9000 leader mark followed by a 2250 space is a repeat frame;
// followed by a 4500 space it starts 32 bits of 560 mark plus a 560 (zero)
// or 1690 (one) space, first bit most significant. On the flagged duration
// one result beat leaves with frame_ok, is_repeat and key_code (zero unless
// a complete data frame decoded). The block takes one duration per cycle while
// full is low. A beat is classified against all windows as it is pushed and
// waits in a four-entry queue; the frame sequencer then consumes one entry per
// cycle unless stalled and writes frame results into a two-entry result queue.
// The only stall comes from that result queue: while it holds two untaken results,
// a frame-end duration waits in front of the sequencer, and full rises once the
// classification queue has filled behind it. A pushed duration is registered in
// the classification queue, its frame result in the result queue. Configuration
// writes complete in the usual setup and access cycles, with pready tied high.
module nec_ir_frame_decoder import nif_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,

	input  logic              push,
	output logic              full,
	input  item_t             item,

	output logic              empty,
	input  logic              pop,
	output result_t           result
);

	logic [MARGIN_W-1:0] margin_q;
	logic                cfg_wr;
	logic                in_fire;
	class_t              cls_in;
	class_t              cls_out;
	logic                cls_valid;
	logic                cls_take;

	// The register index is the word address; only register zero exists.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MATCH_MARGIN);
	assign prdata = (paddr[2] == REG_MATCH_MARGIN) ? 32'(margin_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_wr) begin
			margin_q <= pwdata[MARGIN_W-1:0];
		end
	end

	assign in_fire = push && !full;

	// Front: window comparisons against the current margin.
	nif_front u_front (
		.margin (margin_q),
		.item   (item),
		.cls    (cls_in)
	);

	// Decouples classification from the frame sequencer.
	nif_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_fire),
		.wr_data  (cls_in),
		.full     (full),
		.rd_en    (cls_take),
		.rd_valid (cls_valid),
		.rd_data  (cls_out)
	);

	// Back: frame position, bit collection and the result queue.
	nif_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls       (cls_out),
		.cls_take  (cls_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
